[rtl/core/fall_detect_countdown_defines.svh]
// assertion macros for the fall detector rtl, used by fdc_decide
// expects clk and rst_n in scope at the point of use
`ifndef FALL_DETECT_COUNTDOWN_DEFINES_SVH
`define FALL_DETECT_COUNTDOWN_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fdc_pkg.sv]
// shared types and constants for the fall detector
// no dependencies
`timescale 1ns / 1ps

package fdc_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int NOW_MS_W       = 32;
    localparam int ACCEL_W        = 16;
    localparam int ABS_W          = 16;
    localparam int SQ_W           = 31;
    localparam int MAG2_W         = 32;
    localparam int LEVEL_W        = 15;
    localparam int SUM_W          = 16;
    localparam int HI_SQ_W        = 32;
    localparam int LO_SQ_W        = 30;
    localparam int HOLD_W         = 16;
    localparam int TMO_W          = 24;
    localparam int DIFF_W         = 24;
    localparam int SECS_W         = 15;
    localparam int CFG_DATA_W     = 24;
    localparam int CFG_INDEX_W    = 3;

    // divide by 1000 as multiply by reciprocal, exact for 24-bit dividends
    localparam int          RECIP_W     = 25;
    localparam int          RECIP_SHIFT = 34;
    localparam logic [24:0] RECIP_1000  = 25'd17179870;
    localparam int          MUL_W       = DIFF_W + RECIP_W;

    localparam logic [LEVEL_W-1:0] FALL_THRESHOLD_RST = 15'd4608;
    localparam logic [LEVEL_W-1:0] GRAVITY_LEVEL_RST  = 15'd2511;
    localparam logic [LEVEL_W-1:0] MOTION_MARGIN_RST  = 15'd768;
    localparam logic [HOLD_W-1:0]  CANCEL_HOLD_RST    = 16'd3000;
    localparam logic [TMO_W-1:0]   RESP_TIMEOUT_RST   = 24'd60000;

    // squared bounds at reset: (2511+768)^2, (2511-768)^2, 4608^2
    localparam logic [HI_SQ_W-1:0] HI_SQ_RST  = 32'd10751841;
    localparam logic [LO_SQ_W-1:0] LO_SQ_RST  = 30'd3038049;
    localparam logic [LO_SQ_W-1:0] THR_SQ_RST = 30'd21233664;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FALL_THRESHOLD = 3'd0,
        CFG_GRAVITY_LEVEL  = 3'd1,
        CFG_MOTION_MARGIN  = 3'd2,
        CFG_CANCEL_HOLD    = 3'd3,
        CFG_RESP_TIMEOUT   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [HI_SQ_W-1:0] hi_sq;
        logic [LO_SQ_W-1:0] lo_sq;
        logic [LO_SQ_W-1:0] thr_sq;
    } fdc_bounds_t;

    typedef struct packed {
        logic moving;
        logic detected;
        logic cancelled;
        logic no_response;
        logic in_fall;
    } fdc_flags_t;

endpackage

[rtl/core/fall_detect_countdown.sv]
// top level of the accelerometer fall detector with no-response countdown
// depends on fdc_pkg and fdc_decide
`timescale 1ns / 1ps

// Takes one acceleration sample per clock cycle and returns one result word per sample,
// in order, through the input register, squaring stage, decision stage and then the output
// register, where the countdown divide by 1000 is done as a reciprocal multiply. Fall mode
// state is updated in the decision stage, so back-to-back samples see the state left by
// the previous one. Magnitudes are compared as squares against bounds that are squared
// from the configuration registers into a bounds register after a configuration write.
// Timestamps are taken modulo 2^TIME_WIDTH. Full throughput is kept as long as out_ready
// stays high; each stage holds its word while the stage after it is stalled.

module fall_detect_countdown #(
    parameter int TIME_WIDTH = fdc_pkg::TIME_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fdc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [fdc_pkg::ACCEL_W-1:0]  accel_x,
    input  logic signed [fdc_pkg::ACCEL_W-1:0]  accel_y,
    input  logic signed [fdc_pkg::ACCEL_W-1:0]  accel_z,
    input  logic [fdc_pkg::NOW_MS_W-1:0]        now_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                moving,
    output logic                                fall_detected,
    output logic                                fall_cancelled,
    output logic                                no_response,
    output logic                                in_fall_mode,
    output logic [fdc_pkg::SECS_W-1:0]          seconds_left
);

    localparam int ACCEL_W = fdc_pkg::ACCEL_W;
    localparam int ABS_W   = fdc_pkg::ABS_W;
    localparam int SQ_W    = fdc_pkg::SQ_W;
    localparam int SUM_W   = fdc_pkg::SUM_W;
    localparam int LEVEL_W = fdc_pkg::LEVEL_W;
    localparam int HI_SQ_W = fdc_pkg::HI_SQ_W;
    localparam int LO_SQ_W = fdc_pkg::LO_SQ_W;
    localparam int MUL_W   = fdc_pkg::MUL_W;

    // configuration
    logic [LEVEL_W-1:0]              thr_reg;
    logic [LEVEL_W-1:0]              grav_reg;
    logic [LEVEL_W-1:0]              margin_reg;
    logic [fdc_pkg::HOLD_W-1:0]      hold_reg;
    logic [fdc_pkg::TMO_W-1:0]       tmo_reg;
    fdc_pkg::fdc_bounds_t            bounds_reg;
    fdc_pkg::fdc_bounds_t            bounds_next;
    logic [SUM_W-1:0]                hi_sum;
    logic [LEVEL_W-1:0]              lo_diff;

    // pipeline
    logic                            s1_valid_reg, s1_valid_next;
    logic signed [ACCEL_W-1:0]       ax_reg, ay_reg, az_reg;
    logic [fdc_pkg::NOW_MS_W-1:0]    now1_reg;
    logic                            s2_valid_reg, s2_valid_next;
    logic [SQ_W-1:0]                 sqx_reg, sqy_reg, sqz_reg;
    logic [SQ_W-1:0]                 sqx_next, sqy_next, sqz_next;
    logic [fdc_pkg::NOW_MS_W-1:0]    now2_reg;
    logic                            s3_valid_reg, s3_valid_next;
    fdc_pkg::fdc_flags_t             flags3_reg;
    logic [fdc_pkg::DIFF_W-1:0]      diff3_reg;
    logic                            out_valid_reg, out_valid_next;
    fdc_pkg::fdc_flags_t             out_flags_reg;
    logic [fdc_pkg::SECS_W-1:0]      secs_reg, secs_next;

    logic                            in_accept;
    logic                            out_free;
    logic                            s3_ready, s3_go;
    logic                            s2_ready, s2_go;
    logic                            s1_go;
    fdc_pkg::fdc_flags_t             dec_flags;
    logic [fdc_pkg::DIFF_W-1:0]      dec_diff;
    logic [MUL_W-1:0]                prod;

    function automatic logic [SQ_W-1:0] square_axis(input logic signed [ACCEL_W-1:0] v);
        logic [ABS_W-1:0]   mag;
        logic [2*ABS_W-1:0] sq;
        mag = v[ACCEL_W-1] ? ABS_W'(-v) : ABS_W'(v);
        sq  = (2*ABS_W)'(mag) * (2*ABS_W)'(mag);
        return sq[SQ_W-1:0];
    endfunction

    // handshake chain
    assign out_free  = !out_valid_reg || out_ready;
    assign s3_go     = s3_valid_reg && out_free;
    assign s3_ready  = !s3_valid_reg || out_free;
    assign s2_go     = s2_valid_reg && s3_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_go     = s1_valid_reg && s2_ready;
    assign in_ready  = !s1_valid_reg || s2_ready;
    assign in_accept = in_valid && in_ready;

    assign s1_valid_next  = in_accept || (s1_valid_reg && !s1_go);
    assign s2_valid_next  = s1_go || (s2_valid_reg && !s2_go);
    assign s3_valid_next  = s2_go || (s3_valid_reg && !s3_go);
    assign out_valid_next = s3_go || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers and squared bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= fdc_pkg::FALL_THRESHOLD_RST;
            grav_reg   <= fdc_pkg::GRAVITY_LEVEL_RST;
            margin_reg <= fdc_pkg::MOTION_MARGIN_RST;
            hold_reg   <= fdc_pkg::CANCEL_HOLD_RST;
            tmo_reg    <= fdc_pkg::RESP_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fdc_pkg::CFG_FALL_THRESHOLD: thr_reg    <= cfg_data[LEVEL_W-1:0];
                fdc_pkg::CFG_GRAVITY_LEVEL:  grav_reg   <= cfg_data[LEVEL_W-1:0];
                fdc_pkg::CFG_MOTION_MARGIN:  margin_reg <= cfg_data[LEVEL_W-1:0];
                fdc_pkg::CFG_CANCEL_HOLD:    hold_reg   <= cfg_data[fdc_pkg::HOLD_W-1:0];
                fdc_pkg::CFG_RESP_TIMEOUT:   tmo_reg    <= cfg_data[fdc_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // lower bound clamps to zero when margin reaches gravity
    assign hi_sum  = SUM_W'(grav_reg) + SUM_W'(margin_reg);
    assign lo_diff = (grav_reg > margin_reg) ? (grav_reg - margin_reg) : '0;

    always_comb
    begin
        bounds_next.hi_sq  = HI_SQ_W'(hi_sum) * HI_SQ_W'(hi_sum);
        bounds_next.lo_sq  = LO_SQ_W'(lo_diff) * LO_SQ_W'(lo_diff);
        bounds_next.thr_sq = LO_SQ_W'(thr_reg) * LO_SQ_W'(thr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg.hi_sq  <= fdc_pkg::HI_SQ_RST;
            bounds_reg.lo_sq  <= fdc_pkg::LO_SQ_RST;
            bounds_reg.thr_sq <= fdc_pkg::THR_SQ_RST;
        end
        else
        begin
            bounds_reg <= bounds_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ax_reg   <= accel_x;
            ay_reg   <= accel_y;
            az_reg   <= accel_z;
            now1_reg <= now_ms;
        end
    end

    // squaring stage
    assign sqx_next = square_axis(ax_reg);
    assign sqy_next = square_axis(ay_reg);
    assign sqz_next = square_axis(az_reg);

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            sqx_reg  <= sqx_next;
            sqy_reg  <= sqy_next;
            sqz_reg  <= sqz_next;
            now2_reg <= now1_reg;
        end
    end

    // decision stage
    fdc_decide #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_decide (
        .clk                 (clk),
        .rst_n               (rst_n),
        .advance             (s2_go),
        .sq_x                (sqx_reg),
        .sq_y                (sqy_reg),
        .sq_z                (sqz_reg),
        .now_ms              (now2_reg),
        .bounds              (bounds_reg),
        .cancel_hold_ms      (hold_reg),
        .response_timeout_ms (tmo_reg),
        .flags               (dec_flags),
        .diff                (dec_diff)
    );

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            flags3_reg <= dec_flags;
            diff3_reg  <= dec_diff;
        end
    end

    // whole seconds left
    assign prod      = MUL_W'(diff3_reg) * MUL_W'(fdc_pkg::RECIP_1000);
    assign secs_next = prod[fdc_pkg::RECIP_SHIFT +: fdc_pkg::SECS_W];

    always_ff @(posedge clk)
    begin
        if (s3_go)
        begin
            out_flags_reg <= flags3_reg;
            secs_reg      <= secs_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign moving         = out_flags_reg.moving;
    assign fall_detected  = out_flags_reg.detected;
    assign fall_cancelled = out_flags_reg.cancelled;
    assign no_response    = out_flags_reg.no_response;
    assign in_fall_mode   = out_flags_reg.in_fall;
    assign seconds_left   = secs_reg;

endmodule

[rtl/core/fdc_decide.sv]
// fall mode state and per-sample decision logic
// depends on fdc_pkg and fall_detect_countdown_defines.svh
`timescale 1ns / 1ps
`include "fall_detect_countdown_defines.svh"

module fdc_decide #(
    parameter int TIME_WIDTH = fdc_pkg::TIME_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic [fdc_pkg::SQ_W-1:0]         sq_x,
    input  logic [fdc_pkg::SQ_W-1:0]         sq_y,
    input  logic [fdc_pkg::SQ_W-1:0]         sq_z,
    input  logic [fdc_pkg::NOW_MS_W-1:0]     now_ms,
    input  fdc_pkg::fdc_bounds_t             bounds,
    input  logic [fdc_pkg::HOLD_W-1:0]       cancel_hold_ms,
    input  logic [fdc_pkg::TMO_W-1:0]        response_timeout_ms,
    output fdc_pkg::fdc_flags_t              flags,
    output logic [fdc_pkg::DIFF_W-1:0]       diff
);

    localparam int NOW_W  = (TIME_WIDTH < fdc_pkg::NOW_MS_W) ? TIME_WIDTH : fdc_pkg::NOW_MS_W;
    localparam int CMP_W  = (TIME_WIDTH > fdc_pkg::TMO_W) ? TIME_WIDTH : fdc_pkg::TMO_W;
    localparam int MAG2_W = fdc_pkg::MAG2_W;
    localparam int DIFF_W = fdc_pkg::DIFF_W;

    logic                  active_reg;
    logic                  active_next;
    logic [TIME_WIDTH-1:0] start_reg;
    logic [TIME_WIDTH-1:0] start_next;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [CMP_W-1:0]      elapsed_c;
    logic [CMP_W-1:0]      hold_c;
    logic [CMP_W-1:0]      tmo_c;
    logic [MAG2_W-1:0]     mag2;

    assign mag2      = MAG2_W'(sq_x) + MAG2_W'(sq_y) + MAG2_W'(sq_z);
    assign now_t     = TIME_WIDTH'(now_ms[NOW_W-1:0]);
    assign elapsed   = now_t - start_reg;
    assign elapsed_c = CMP_W'(elapsed);
    assign hold_c    = CMP_W'(cancel_hold_ms);
    assign tmo_c     = CMP_W'(response_timeout_ms);

    always_comb
    begin
        flags       = '0;
        diff        = '0;
        active_next = active_reg;
        start_next  = start_reg;
        flags.moving = (mag2 > bounds.hi_sq) || (mag2 < MAG2_W'(bounds.lo_sq));
        if (!active_reg)
        begin
            if (mag2 > MAG2_W'(bounds.thr_sq))
            begin
                active_next    = 1'b1;
                start_next     = now_t;
                flags.detected = 1'b1;
            end
        end
        else
        begin
            if ((elapsed_c > hold_c) && flags.moving)
            begin
                active_next     = 1'b0;
                flags.cancelled = 1'b1;
            end
            if (elapsed_c > tmo_c)
            begin
                flags.no_response = 1'b1;
            end
            else
            begin
                diff = DIFF_W'(tmo_c - elapsed_c);
            end
        end
        flags.in_fall = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            start_reg  <= '0;
        end
        else if (advance)
        begin
            active_reg <= active_next;
            start_reg  <= start_next;
        end
    end

    `FDC_ASSERT_NEXT(a_detect_enters_fall, advance && flags.detected, active_reg, "detection did not enter fall mode")
    `FDC_ASSERT_NEXT(a_cancel_leaves_fall, advance && flags.cancelled, !active_reg, "cancel did not leave fall mode")
    `FDC_ASSERT_NOW(a_timeout_no_count, flags.no_response, diff == '0, "countdown nonzero after timeout")
    `FDC_ASSERT_NEXT(a_start_holds, !(advance && flags.detected), $stable(start_reg), "fall start time changed without detection")

endmodule

[verif/tb_fall_detect_countdown.sv]
// testbench for fall_detect_countdown: directed and random sample streams with a scoreboard
// that predicts every result word; depends on fdc_pkg and the fall_detect_countdown rtl
`timescale 1ns / 1ps

module tb_fall_detect_countdown;

    localparam int LIMIT_CYCLES = 300000;

    typedef struct packed {
        logic                       moving;
        logic                       detected;
        logic                       cancelled;
        logic                       no_resp;
        logic                       in_fall;
        logic [fdc_pkg::SECS_W-1:0] secs;
    } fall_word_t;

    class fall_scoreboard;
        logic [fdc_pkg::LEVEL_W-1:0] thr_level;
        logic [fdc_pkg::LEVEL_W-1:0] grav_level;
        logic [fdc_pkg::LEVEL_W-1:0] move_margin;
        logic [fdc_pkg::HOLD_W-1:0]  hold_ms;
        logic [fdc_pkg::TMO_W-1:0]   timeout_ms;
        bit                          fall_on;
        logic [31:0]                 fall_t0;
        fall_word_t                  pending_q[$];
        int n_samples;
        int n_results;
        int n_errors;
        int n_falls;
        int n_cancels;
        int n_alarms;
        int n_settings;

        function new();
            thr_level   = fdc_pkg::FALL_THRESHOLD_RST;
            grav_level  = fdc_pkg::GRAVITY_LEVEL_RST;
            move_margin = fdc_pkg::MOTION_MARGIN_RST;
            hold_ms     = fdc_pkg::CANCEL_HOLD_RST;
            timeout_ms  = fdc_pkg::RESP_TIMEOUT_RST;
            fall_on     = 1'b0;
            fall_t0     = '0;
        endfunction

        function void set_reg(fdc_pkg::cfg_index_t idx,
                              logic [fdc_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                fdc_pkg::CFG_FALL_THRESHOLD: thr_level   = value[fdc_pkg::LEVEL_W-1:0];
                fdc_pkg::CFG_GRAVITY_LEVEL:  grav_level  = value[fdc_pkg::LEVEL_W-1:0];
                fdc_pkg::CFG_MOTION_MARGIN:  move_margin = value[fdc_pkg::LEVEL_W-1:0];
                fdc_pkg::CFG_CANCEL_HOLD:    hold_ms     = value[fdc_pkg::HOLD_W-1:0];
                fdc_pkg::CFG_RESP_TIMEOUT:   timeout_ms  = value[fdc_pkg::TMO_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [fdc_pkg::ACCEL_W-1:0] ax,
                                  logic signed [fdc_pkg::ACCEL_W-1:0] ay,
                                  logic signed [fdc_pkg::ACCEL_W-1:0] az,
                                  logic [31:0] now_val);
            longint unsigned mag2;
            longint unsigned hi;
            longint unsigned lo;
            longint unsigned thr_sq;
            logic [31:0]     elapsed;
            fall_word_t      w;
            mag2 = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
                 + longint'(az) * longint'(az);
            hi = longint'(grav_level) + longint'(move_margin);
            thr_sq = longint'(thr_level) * longint'(thr_level);
            w = '0;
            w.moving = mag2 > hi * hi;
            // lower bound clamps to zero when the margin swallows gravity
            if (grav_level > move_margin)
            begin
                lo = longint'(grav_level) - longint'(move_margin);
                if (mag2 < lo * lo)
                    w.moving = 1'b1;
            end
            if (!fall_on)
            begin
                if (mag2 > thr_sq)
                begin
                    fall_on    = 1'b1;
                    fall_t0    = now_val;
                    w.detected = 1'b1;
                    n_falls++;
                end
            end
            else
            begin
                elapsed = now_val - fall_t0;
                if (elapsed > hold_ms && w.moving)
                begin
                    fall_on     = 1'b0;
                    w.cancelled = 1'b1;
                    n_cancels++;
                end
                if (elapsed > timeout_ms)
                begin
                    w.no_resp = 1'b1;
                    n_alarms++;
                end
                else
                    w.secs = fdc_pkg::SECS_W'((timeout_ms - elapsed) / 1000);
            end
            w.in_fall = fall_on;
            pending_q.push_back(w);
            n_samples++;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            n_errors++;
            $display("mismatch: %s at result %0d, got %0h, expected %0h",
                     what, n_results, got, want);
        endtask

        task check_result(fall_word_t got);
            fall_word_t want;
            n_results++;
            if (pending_q.size() == 0)
            begin
                report_mismatch("word with no sample pending", '0, '0);
                return;
            end
            want = pending_q.pop_front();
            if (got.moving !== want.moving)
                report_mismatch("moving", got.moving, want.moving);
            if (got.detected !== want.detected)
                report_mismatch("fall_detected", got.detected, want.detected);
            if (got.cancelled !== want.cancelled)
                report_mismatch("fall_cancelled", got.cancelled, want.cancelled);
            if (got.no_resp !== want.no_resp)
                report_mismatch("no_response", got.no_resp, want.no_resp);
            if (got.in_fall !== want.in_fall)
                report_mismatch("in_fall_mode", got.in_fall, want.in_fall);
            if (got.secs !== want.secs)
                report_mismatch("seconds_left", got.secs, want.secs);
        endtask
    endclass

    logic                               clk;
    logic                               rst_n = 1'b0;
    logic                               cfg_we = 1'b0;
    fdc_pkg::cfg_index_t                cfg_index = fdc_pkg::CFG_FALL_THRESHOLD;
    logic [fdc_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic signed [fdc_pkg::ACCEL_W-1:0] accel_x = '0;
    logic signed [fdc_pkg::ACCEL_W-1:0] accel_y = '0;
    logic signed [fdc_pkg::ACCEL_W-1:0] accel_z = '0;
    logic [fdc_pkg::NOW_MS_W-1:0]       now_ms = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic                               moving;
    logic                               fall_detected;
    logic                               fall_cancelled;
    logic                               no_response;
    logic                               in_fall_mode;
    logic [fdc_pkg::SECS_W-1:0]         seconds_left;

    fall_scoreboard board = new();
    bit                tx_burst = 1'b0;
    bit                rx_burst = 1'b0;
    bit                pause_done = 1'b0;
    logic [31:0]       clock_ms = 32'd20000;
    int                cycle_cnt = 0;

    fall_detect_countdown u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .moving         (moving),
        .fall_detected  (fall_detected),
        .fall_cancelled (fall_cancelled),
        .no_response    (no_response),
        .in_fall_mode   (in_fall_mode),
        .seconds_left   (seconds_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom % 100;
        if (tx_burst || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clamp_mag(int v);
        if (v < 0)
            return 0;
        if (v > 32768)
            return 32768;
        return v;
    endfunction

    function automatic int still_mag();
        int m;
        m = board.move_margin;
        return clamp_mag(int'(board.grav_level) + int'($urandom_range(0, m)) - m / 2);
    endfunction

    function automatic int moving_mag();
        int g;
        int m;
        g = board.grav_level;
        m = board.move_margin;
        if (g > m && $urandom % 2)
            return clamp_mag(g - m - int'($urandom_range(1, 1500)));
        return clamp_mag(g + m + int'($urandom_range(1, 3000)));
    endfunction

    function automatic int boundary_mag();
        int g;
        int m;
        int lo;
        g = board.grav_level;
        m = board.move_margin;
        lo = (g > m) ? g - m : 0;
        case ($urandom % 6)
            0: return clamp_mag(g + m);
            1: return clamp_mag(g + m + 1);
            2: return lo;
            3: return clamp_mag(lo - 1);
            4: return board.thr_level;
            default: return clamp_mag(int'(board.thr_level) + 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_elapsed();
        int unsigned h;
        int unsigned t;
        h = board.hold_ms;
        t = board.timeout_ms;
        case ($urandom % 9)
            0: return $urandom_range(0, h);
            1: return h;
            2: return h + 1;
            3: return $urandom_range(h, t);
            4: return t;
            5: return t + 1;
            6: return t + $urandom_range(0, 100000);
            7: return $urandom;
            default: return $urandom_range(0, 50);
        endcase
    endfunction

    task automatic send_sample(input int ax, input int ay, input int az, input logic [31:0] t);
        int gap;
        in_valid <= 1'b1;
        accel_x  <= 16'(ax);
        accel_y  <= 16'(ay);
        accel_z  <= 16'(az);
        now_ms   <= t;
        do @(posedge clk); while (!in_ready);
        board.note_sample(16'(ax), 16'(ay), 16'(az), t);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // puts the magnitude on one random axis, optionally with a little jitter on the others
    task automatic send_mag(input int mag, input bit jitter, input logic [31:0] t);
        int v[3];
        int axis;
        axis = $urandom % 3;
        for (int k = 0; k < 3; k++)
            v[k] = jitter ? int'($urandom_range(0, 16)) - 8 : 0;
        v[axis] = (mag >= 32768) ? -32768 : (($urandom % 2) ? -mag : mag);
        send_sample(v[0], v[1], v[2], t);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input fdc_pkg::cfg_index_t idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= fdc_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        board.set_reg(idx, fdc_pkg::CFG_DATA_W'(value));
    endtask

    task automatic load_settings(input int unsigned thr, input int unsigned g,
                                 input int unsigned m, input int unsigned h,
                                 input int unsigned tmo);
        write_reg(fdc_pkg::CFG_FALL_THRESHOLD, thr);
        write_reg(fdc_pkg::CFG_GRAVITY_LEVEL, g);
        write_reg(fdc_pkg::CFG_MOTION_MARGIN, m);
        write_reg(fdc_pkg::CFG_CANCEL_HOLD, h);
        write_reg(fdc_pkg::CFG_RESP_TIMEOUT, tmo);
        cfg_we <= 1'b0;
        board.n_settings++;
        // squared bounds settle in the cycle after the write
        repeat (3) @(posedge clk);
    endtask

    // quiet samples, a spike, then a burst of samples at chosen times since the spike
    task automatic run_episode();
        int          sel;
        logic [31:0] t0;
        logic [31:0] el;
        if ($urandom_range(0, 19) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4000);
        repeat ($urandom_range(1, 3))
        begin
            clock_ms += $urandom_range(10, 300);
            send_mag(still_mag(), 1'b1, clock_ms);
        end
        clock_ms += $urandom_range(10, 300);
        send_mag(clamp_mag(int'(board.thr_level) + int'($urandom_range(1, 4000))), 1'b1,
                 clock_ms);
        t0 = clock_ms;
        repeat ($urandom_range(2, 10))
        begin
            el = pick_elapsed();
            sel = $urandom % 10;
            if (sel < 5)
                send_mag(still_mag(), 1'b1, t0 + el);
            else if (sel < 8)
                send_mag(moving_mag(), 1'b1, t0 + el);
            else
                send_mag(boundary_mag(), 1'b0, t0 + el);
            clock_ms = t0 + el;
        end
    endtask

    task automatic run_phase(input int unsigned thr, input int unsigned g,
                             input int unsigned m, input int unsigned h,
                             input int unsigned tmo, input int n_words, input bit burst);
        int target;
        drain();
        load_settings(thr, g, m, h, tmo);
        tx_burst = burst;
        rx_burst = burst;
        target = board.n_samples + n_words;
        while (board.n_samples < target)
        begin
            if (!pause_done && board.n_samples >= 560)
            begin
                drain();
                pause_done = 1'b1;
            end
            if ($urandom % 10 < 2)
                send_sample($urandom, $urandom, $urandom, $urandom);
            else
                run_episode();
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    task automatic run_realistic(input int n_words, input bit burst);
        run_phase($urandom_range(3000, 9000), $urandom_range(2300, 2700),
                  $urandom_range(200, 1200), $urandom_range(0, 6000),
                  $urandom_range(1000, 100000), n_words, burst);
    endtask

    // result side: checks every accepted word and stalls at random
    initial
    begin
        int stall_left;
        bit long_done;
        stall_left = 0;
        long_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_result({moving, fall_detected, fall_cancelled, no_response,
                                    in_fall_mode, seconds_left});
            if (!long_done && board.n_samples >= 420)
            begin
                stall_left = 300;
                long_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (rx_burst || $urandom % 100 < 70)
                out_ready <= 1'b1;
            else
            begin
                stall_left = ($urandom % 10 < 8) ? $urandom_range(0, 2) : $urandom_range(7, 39);
                out_ready <= 1'b0;
            end
        end
    end

    initial
    begin
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles with %0d words outstanding",
                 cycle_cnt, board.pending_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int wait_cnt;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: bounds, strict compares, hold, timeout and wrap
        send_sample(0, 0, 0, 1000);
        send_sample(2511, 0, 0, 1010);
        send_sample(3279, 0, 0, 1020);
        send_sample(-3280, 0, 0, 1030);
        send_sample(0, 1743, 0, 1040);
        send_sample(0, 0, -1742, 1050);
        send_sample(4608, 0, 0, 1060);
        send_sample(-32768, -32768, -32768, 2000);
        send_sample(0, 0, 0, 5000);
        send_sample(0, 2511, 0, 5001);
        send_sample(0, 0, 2511, 62000);
        send_sample(0, 0, 2511, 62001);
        send_sample(32767, 32767, 32767, 70000);
        send_sample(32767, 0, 0, 32'hFFFF_FF00);
        send_sample(0, 0, 2511, 32'h0000_0100);
        send_sample(0, 0, 0, 32'h0000_0C00);
        send_sample(0, -4700, 0, 9000);
        send_sample(0, 0, 0, 9100);
        send_sample(0, 0, 7000, 12500);
        send_sample(5000, 5000, 5000, 32'hFFFF_FFFF);

        // margin above gravity: only the upper bound flags movement
        drain();
        write_reg(fdc_pkg::CFG_GRAVITY_LEVEL, 100);
        write_reg(fdc_pkg::CFG_MOTION_MARGIN, 500);
        cfg_we <= 1'b0;
        repeat (3) @(posedge clk);
        send_sample(0, 0, 0, 100);
        send_sample(601, 0, 0, 4000);
        send_sample(600, 0, 0, 4100);

        run_phase(0, 0, 0, 0, 0, 110, 1'b0);
        run_phase(32767, 32767, 32767, 65535, 24'hFFFFFF, 110, 1'b0);
        run_phase($urandom_range(3000, 9000), 300, $urandom_range(300, 2000),
                  $urandom_range(0, 65535), $urandom_range(0, 200000), 115, 1'b0);
        run_realistic(120, 1'b1);
        run_realistic(120, 1'b0);
        run_realistic(120, 1'b0);

        in_valid <= 1'b0;
        wait_cnt = 0;
        while (board.pending_q.size() != 0 && wait_cnt < 5000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (10) @(posedge clk);
        if (board.pending_q.size() != 0)
            board.report_mismatch("samples left without a result word",
                                  board.pending_q.size(), 0);

        $display("covered %0d samples, %0d result words, %0d register settings",
                 board.n_samples, board.n_results, board.n_settings + 2);
        $display("predicted %0d falls, %0d movement cancels, %0d no-response flags",
                 board.n_falls, board.n_cancels, board.n_alarms);
        if (board.n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
